// ----- hw/rtl/bss_pkg.sv -----
// Shared types and constants of the boosted stump scorer.
package bss_pkg;

   localparam int STUMPS_PER_SET_DEF = 128;
   localparam int OP_W = 3;
   localparam int SLOT_W = 7;
   localparam int VAL_W = 32;
   localparam int SCORE_W = 40;
   localparam int HITS_W = 24;
   localparam int CNT_CFG_W = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_WRITE_LOW  = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_HIGH = 3'd1;
   localparam logic [OP_W-1:0] OP_CLASSIFY   = 3'd2;
   localparam logic [OP_W-1:0] OP_POSITIVE   = 3'd3;
   localparam logic [OP_W-1:0] OP_NEGATIVE   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR_CAL  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd2;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

   typedef struct packed {
      logic                    lo;
      logic                    hi;
      logic [SLOT_W-1:0]       slot;
      logic signed [VAL_W-1:0] bound;
      logic signed [VAL_W-1:0] weight;
   } stump_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/bss_cell.sv -----
// One cell of the stump chain: holds one stump of each set and adds its votes.
module bss_cell #(
   parameter int IDX = 0,
   parameter int CNT_W = 8,
   parameter int ACC_W = 44
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bss_pkg::stump_wr_type         wr,
   input  logic [CNT_W-1:0]              n_low,
   input  logic [CNT_W-1:0]              n_high,
   input  logic                          tok_valid_i,
   input  logic signed [bss_pkg::VAL_W-1:0] tok_value_i,
   input  logic signed [ACC_W-1:0]       tok_acc_i,
   output logic                          tok_valid_o,
   output logic signed [bss_pkg::VAL_W-1:0] tok_value_o,
   output logic signed [ACC_W-1:0]       tok_acc_o
);
   import bss_pkg::*;

   logic signed [VAL_W-1:0] lo_bound_ff, lo_weight_ff, hi_bound_ff, hi_weight_ff;
   logic                    valid_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] lo_ext, hi_ext, lo_term, hi_term;
   logic                    lo_en, hi_en, slot_hit;

   assign slot_hit = (int'(wr.slot) == IDX);
   assign lo_en = (IDX < int'(n_low));
   assign hi_en = (IDX < int'(n_high));
   assign lo_ext = ACC_W'(lo_weight_ff);
   assign hi_ext = ACC_W'(hi_weight_ff);

   always_comb begin
      lo_term = '0;
      hi_term = '0;
      if (lo_en) begin
         lo_term = (tok_value_i < lo_bound_ff) ? lo_ext : -lo_ext;
      end
      if (hi_en) begin
         hi_term = (tok_value_i >= hi_bound_ff) ? hi_ext : -hi_ext;
      end
      acc_in = tok_acc_i + lo_term + hi_term;
   end

   always_ff @(posedge clock) begin
      if (wr.lo && slot_hit) begin
         lo_bound_ff <= wr.bound;
         lo_weight_ff <= wr.weight;
      end
      if (wr.hi && slot_hit) begin
         hi_bound_ff <= wr.bound;
         hi_weight_ff <= wr.weight;
      end
      value_ff <= tok_value_i;
      acc_ff <= acc_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_valid_i;
      end
   end

   assign tok_valid_o = valid_ff;
   assign tok_value_o = value_ff;
   assign tok_acc_o = acc_ff;

endmodule

// ----- hw/rtl/boosted_stump_scorer.sv -----
// Top level of the boosted stump scorer: stump chain, sequencer and calibration.
//
// The req channel carries one op per item; the rsp channel returns exactly one
// result item per request item, in order. Both use valid and stall.
// Write ops load one stump of set 0 or set 1 into the cell chosen by slot.
// Scoring ops (classify, positive, negative) send the sample down a chain of
// STUMPS_PER_SET cells, one cell per cycle; each cell adds the votes of its
// set-0 and set-1 stump, so both sets are walked in parallel.
// Scoring ops pass the cell chain, the sum register and the rsp register; all
// other ops go to the rsp register alone. One item is in flight at a time;
// a new item is accepted once the previous result sits in the rsp register.
// A result waits in the rsp register while rsp_stall is high; the block holds
// the finished item and takes no further item until the register frees.
// Reset clears the control state, the configuration registers and the
// calibration state (minimum to the largest score, count to zero). Stump
// entries are undefined until written.
module boosted_stump_scorer #(
   parameter int STUMPS_PER_SET = bss_pkg::STUMPS_PER_SET_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bss_pkg::OP_W-1:0]            req_op,
   input  logic [bss_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [bss_pkg::VAL_W-1:0]    req_stump_bound,
   input  logic signed [bss_pkg::VAL_W-1:0]    req_stump_weight,
   input  logic signed [bss_pkg::VAL_W-1:0]    req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bss_pkg::SCORE_W-1:0]  rsp_score,
   output logic                                rsp_decision,
   output logic signed [bss_pkg::SCORE_W-1:0]  rsp_min_positive_score,
   output logic [bss_pkg::HITS_W-1:0]          rsp_true_negative_count,
   input  logic                                csr_write,
   input  logic [bss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bss_pkg::SCORE_W-1:0]         csr_data
);
   import bss_pkg::*;

   localparam int CNT_W = $clog2(STUMPS_PER_SET + 1);
   localparam int ACC_W = VAL_W + $clog2(2 * STUMPS_PER_SET) + 1;
   localparam int CMP_W = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

   state_type state_ff, state_in;
   logic [CNT_CFG_W-1:0]      act_low_ff, act_high_ff;
   logic signed [SCORE_W-1:0] thr_ff;
   logic [CNT_W-1:0]          n_low, n_high;

   logic                      accept, launch, finish, rsp_free, is_score_op;
   logic [OP_W-1:0]           op_ff;
   logic signed [SCORE_W-1:0] sum_ff, sum_in;
   logic signed [SCORE_W-1:0] min_ff, min_in;
   logic [HITS_W-1:0]         hits_ff, hits_in;
   logic signed [SCORE_W-1:0] score_f;
   logic                      rsp_valid_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_min_ff;
   logic                      rsp_dec_ff;
   logic [HITS_W-1:0]         rsp_hits_ff;
   logic                      score_busy_ff;

   stump_wr_type wr;

   logic                      tok_valid [0:STUMPS_PER_SET];
   logic signed [VAL_W-1:0]   tok_value [0:STUMPS_PER_SET];
   logic signed [ACC_W-1:0]   tok_acc [0:STUMPS_PER_SET];
   logic signed [ACC_W-1:0]   chain_acc;

   function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_CFG_W-1:0] c);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(c);
      if (ext > CMP_W'(STUMPS_PER_SET)) begin
         return CNT_W'(STUMPS_PER_SET);
      end
      return CNT_W'(ext);
   endfunction

   assign n_low = clamp_cnt(act_low_ff);
   assign n_high = clamp_cnt(act_high_ff);

   assign accept = req_valid && !req_stall;
   assign is_score_op = (req_op == OP_CLASSIFY) || (req_op == OP_POSITIVE)
                        || (req_op == OP_NEGATIVE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr.lo = accept && (req_op == OP_WRITE_LOW);
      wr.hi = accept && (req_op == OP_WRITE_HIGH);
      wr.slot = req_slot;
      wr.bound = req_stump_bound;
      wr.weight = req_stump_weight;
   end

   assign tok_valid[0] = launch;
   assign tok_value[0] = req_sample_value;
   assign tok_acc[0] = '0;

   for (genvar i = 0; i < STUMPS_PER_SET; i++) begin : g_cell
      bss_cell #(
         .IDX   (i),
         .CNT_W (CNT_W),
         .ACC_W (ACC_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr          (wr),
         .n_low       (n_low),
         .n_high      (n_high),
         .tok_valid_i (tok_valid[i]),
         .tok_value_i (tok_value[i]),
         .tok_acc_i   (tok_acc[i]),
         .tok_valid_o (tok_valid[i+1]),
         .tok_value_o (tok_value[i+1]),
         .tok_acc_o   (tok_acc[i+1])
      );
   end

   assign chain_acc = tok_acc[STUMPS_PER_SET];

   always_comb begin
      if (chain_acc > ACC_W'(SCORE_MAX)) begin
         sum_in = SCORE_MAX;
      end else if (chain_acc < ACC_W'(SCORE_MIN)) begin
         sum_in = SCORE_MIN;
      end else begin
         sum_in = SCORE_W'(chain_acc);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_score_op ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (tok_valid[STUMPS_PER_SET]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      launch = 1'b0;
      finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            launch = accept && is_score_op;
         end
         ST_SCAN: ;
         ST_FINISH: finish = rsp_free;
         default: ;
      endcase
   end

   assign score_f = score_busy_ff ? sum_ff : '0;

   always_comb begin
      min_in = min_ff;
      hits_in = hits_ff;
      unique case (op_ff)
         OP_POSITIVE: begin
            if (score_f < min_ff) begin
               min_in = score_f;
            end
         end
         OP_NEGATIVE: begin
            if ((score_f < min_ff) && (hits_ff != HITS_MAX)) begin
               hits_in = hits_ff + 1'b1;
            end
         end
         OP_CLEAR_CAL: begin
            min_in = SCORE_MAX;
            hits_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         score_busy_ff <= is_score_op;
      end
      if (state_ff == ST_SCAN && tok_valid[STUMPS_PER_SET]) begin
         sum_ff <= sum_in;
      end
      if (finish) begin
         rsp_score_ff <= score_f;
         rsp_dec_ff <= score_busy_ff && (score_f > thr_ff);
         rsp_min_ff <= min_in;
         rsp_hits_ff <= hits_in;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff <= SCORE_MAX;
         hits_ff <= '0;
         act_low_ff <= '0;
         act_high_ff <= '0;
         thr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            min_ff <= min_in;
            hits_ff <= hits_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_ACTIVE_LOW:  act_low_ff <= csr_data[CNT_CFG_W-1:0];
               CSR_ACTIVE_HIGH: act_high_ff <= csr_data[CNT_CFG_W-1:0];
               CSR_THRESHOLD:   thr_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_decision = rsp_dec_ff;
   assign rsp_min_positive_score = rsp_min_ff;
   assign rsp_true_negative_count = rsp_hits_ff;

endmodule

// ----- hw/rtl/bss_checker.sv -----
// Port-level checks of the boosted stump scorer and their bind.
module bss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [bss_pkg::SCORE_W-1:0] rsp_score,
   input logic                               rsp_decision
);
   import bss_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score) && $stable(rsp_decision))
      else $error("rsp item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while an item is in flight");

   a_free_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("req still stalled after result delivered");

endmodule

bind boosted_stump_scorer bss_checker u_bss_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_score    (rsp_score),
   .rsp_decision (rsp_decision)
);

// ----- sim/boosted_stump_scorer_checker.sv -----
// Score predictor and result comparator for the boosted stump scorer.
module boosted_stump_scorer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [bss_pkg::OP_W-1:0]           req_op,
   input  logic [bss_pkg::SLOT_W-1:0]         req_slot,
   input  logic signed [bss_pkg::VAL_W-1:0]   req_stump_bound,
   input  logic signed [bss_pkg::VAL_W-1:0]   req_stump_weight,
   input  logic signed [bss_pkg::VAL_W-1:0]   req_sample_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [bss_pkg::SCORE_W-1:0] rsp_score,
   input  logic                               rsp_decision,
   input  logic signed [bss_pkg::SCORE_W-1:0] rsp_min_positive_score,
   input  logic [bss_pkg::HITS_W-1:0]         rsp_true_negative_count,
   input  logic                               csr_write,
   input  logic [bss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bss_pkg::SCORE_W-1:0]        csr_data,
   output int                                 mismatches,
   output int                                 pending
);
   import bss_pkg::*;

   localparam int TABLE_DEPTH = STUMPS_PER_SET_DEF;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      decision;
      logic signed [SCORE_W-1:0] minimum;
      logic [HITS_W-1:0]         hits;
   } verdict_type;

   logic signed [VAL_W-1:0]   low_bound_tbl [TABLE_DEPTH];
   logic signed [VAL_W-1:0]   low_weight_tbl [TABLE_DEPTH];
   logic signed [VAL_W-1:0]   high_bound_tbl [TABLE_DEPTH];
   logic signed [VAL_W-1:0]   high_weight_tbl [TABLE_DEPTH];
   logic [CNT_CFG_W-1:0]      low_in_use = '0;
   logic [CNT_CFG_W-1:0]      high_in_use = '0;
   logic signed [SCORE_W-1:0] threshold = '0;
   logic signed [SCORE_W-1:0] lowest_positive = SCORE_MAX;
   logic [HITS_W-1:0]         negatives_below = '0;
   verdict_type               expected_verdicts [$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic logic signed [SCORE_W-1:0] vote_sum(logic signed [VAL_W-1:0] value);
      longint acc;
      int n_low;
      int n_high;
      acc = 0;
      n_low = (low_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(low_in_use);
      n_high = (high_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(high_in_use);
      for (int i = 0; i < n_low; i++) begin
         if (value < low_bound_tbl[i]) acc += low_weight_tbl[i];
         else acc -= low_weight_tbl[i];
      end
      for (int i = 0; i < n_high; i++) begin
         if (value >= high_bound_tbl[i]) acc += high_weight_tbl[i];
         else acc -= high_weight_tbl[i];
      end
      if (acc > longint'(SCORE_MAX)) acc = longint'(SCORE_MAX);
      if (acc < longint'(SCORE_MIN)) acc = longint'(SCORE_MIN);
      return acc[SCORE_W-1:0];
   endfunction

   always @(posedge clock) begin
      verdict_type v;
      verdict_type got;
      if (!reset) begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_ACTIVE_LOW: low_in_use = csr_data[CNT_CFG_W-1:0];
               CSR_ACTIVE_HIGH: high_in_use = csr_data[CNT_CFG_W-1:0];
               CSR_THRESHOLD: threshold = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            v.score = '0;
            v.decision = 1'b0;
            unique case (req_op)
               OP_WRITE_LOW: begin
                  low_bound_tbl[req_slot] = req_stump_bound;
                  low_weight_tbl[req_slot] = req_stump_weight;
               end
               OP_WRITE_HIGH: begin
                  high_bound_tbl[req_slot] = req_stump_bound;
                  high_weight_tbl[req_slot] = req_stump_weight;
               end
               OP_CLASSIFY, OP_POSITIVE, OP_NEGATIVE: begin
                  v.score = vote_sum(req_sample_value);
                  v.decision = v.score > threshold;
                  if (req_op == OP_POSITIVE && v.score < lowest_positive)
                     lowest_positive = v.score;
                  if (req_op == OP_NEGATIVE && v.score < lowest_positive &&
                      negatives_below != HITS_MAX)
                     negatives_below++;
               end
               OP_CLEAR_CAL: begin
                  lowest_positive = SCORE_MAX;
                  negatives_below = '0;
               end
               default: ;
            endcase
            v.minimum = lowest_positive;
            v.hits = negatives_below;
            expected_verdicts.push_back(v);
         end
         if (rsp_valid && !rsp_stall) begin
            got.score = rsp_score;
            got.decision = rsp_decision;
            got.minimum = rsp_min_positive_score;
            got.hits = rsp_true_negative_count;
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item: score %0d", got.score);
            end else begin
               v = expected_verdicts.pop_front();
               if (got.score !== v.score || got.decision !== v.decision ||
                   got.minimum !== v.minimum || got.hits !== v.hits) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: score %0d/%0d decision %0d/%0d min %0d/%0d hits %0d/%0d",
                              v.score, got.score, v.decision, got.decision,
                              v.minimum, got.minimum, v.hits, got.hits);
               end
            end
         end
         pending = expected_verdicts.size();
      end
   end

endmodule

// ----- sim/boosted_stump_scorer_test.sv -----
// Stimulus and verdict for the boosted stump scorer.
module boosted_stump_scorer_test;
   import bss_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op = '0;
   logic [SLOT_W-1:0]         req_slot = '0;
   logic signed [VAL_W-1:0]   req_stump_bound = '0;
   logic signed [VAL_W-1:0]   req_stump_weight = '0;
   logic signed [VAL_W-1:0]   req_sample_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [SCORE_W-1:0] rsp_score;
   logic                      rsp_decision;
   logic signed [SCORE_W-1:0] rsp_min_positive_score;
   logic [HITS_W-1:0]         rsp_true_negative_count;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [SCORE_W-1:0]        csr_data = '0;
   int                        mismatches;
   int                        pending;
   int                        send_idle = 30;
   int                        recv_idle = 73;

   boosted_stump_scorer dut (.*);
   boosted_stump_scorer_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   initial begin
      #50_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic signed [VAL_W-1:0] bound, logic signed [VAL_W-1:0] weight,
                            logic signed [VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_slot <= slot;
      req_stump_bound <= bound;
      req_stump_weight <= weight;
      req_sample_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SCORE_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 3) return $urandom();
      if (r == 3) return VAL_MAX;
      if (r == 4) return VAL_MIN;
      return $signed($urandom_range(400)) - 200;
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_weight();
      if ($urandom_range(3) == 0) return $urandom();
      return $signed($urandom_range(1 << 22)) - (1 << 21);
   endfunction

   task automatic random_item();
      int r;
      logic [OP_W-1:0] op;
      r = $urandom_range(99);
      if (r < 15) op = OP_WRITE_LOW;
      else if (r < 30) op = OP_WRITE_HIGH;
      else if (r < 55) op = OP_CLASSIFY;
      else if (r < 70) op = OP_POSITIVE;
      else if (r < 90) op = OP_NEGATIVE;
      else if (r < 95) op = OP_CLEAR_CAL;
      else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      send_item(op, SLOT_W'($urandom()), pick_value(), pick_weight(), pick_value());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(CSR_ACTIVE_LOW, '0);
      write_csr(CSR_ACTIVE_HIGH, '0);
      write_csr(CSR_THRESHOLD, '0);
      send_item(OP_CLASSIFY, '0, '0, '0, VAL_MAX);
      send_item(OP_NEGATIVE, '0, '0, '0, VAL_MIN);
      send_item(OP_POSITIVE, '0, '0, '0, '0);
      send_item(OP_NEGATIVE, '0, '0, '0, '0);
      send_item(OP_SPARE_A, 7'h7f, VAL_MAX, VAL_MAX, VAL_MAX);
      send_item(OP_SPARE_B, '0, VAL_MIN, VAL_MIN, VAL_MIN);
      send_item(OP_CLEAR_CAL, '0, '0, '0, '0);
      // load every stump with the most negative weight and bounds at the ends of the value range
      for (int i = 0; i < STUMPS_PER_SET_DEF; i++) begin
         send_item(OP_WRITE_LOW, SLOT_W'(i), VAL_MIN, VAL_MIN, '0);
         send_item(OP_WRITE_HIGH, SLOT_W'(i), VAL_MAX, VAL_MIN, '0);
      end
      drain();
      write_csr(CSR_ACTIVE_LOW, SCORE_W'(STUMPS_PER_SET_DEF));
      write_csr(CSR_ACTIVE_HIGH, SCORE_W'(8'hff));
      write_csr(CSR_THRESHOLD, SCORE_MAX);
      send_item(OP_CLASSIFY, '0, '0, '0, '0);
      send_item(OP_POSITIVE, '0, '0, '0, VAL_MAX);
      send_item(OP_NEGATIVE, '0, '0, '0, VAL_MIN);
      send_item(OP_NEGATIVE, '0, '0, '0, '0);
      drain();
      write_csr(CSR_THRESHOLD, SCORE_MIN);
      send_item(OP_CLASSIFY, '0, '0, '0, VAL_MAX);
      send_item(OP_CLASSIFY, '0, '0, '0, VAL_MIN);
      for (int i = 0; i < STUMPS_PER_SET_DEF; i++) begin
         send_item(OP_WRITE_LOW, SLOT_W'(i), pick_value(), pick_weight(), '0);
         send_item(OP_WRITE_HIGH, SLOT_W'(i), pick_value(), pick_weight(), '0);
      end
      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 30 : (mode == 1) ? 73 : 0;
         recv_idle = (mode == 0) ? 73 : (mode == 1) ? 30 : 0;
         for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_csr(CSR_ACTIVE_LOW, SCORE_W'((phase == 0) ? 8'd128 : (phase == 1) ? 8'd0
                                      : 8'($urandom_range(255))));
            write_csr(CSR_ACTIVE_HIGH, SCORE_W'((phase == 1) ? 8'd128 : (phase == 0) ? 8'd1
                                       : 8'($urandom_range(255))));
            write_csr(CSR_THRESHOLD, (phase == 0) ? SCORE_MIN : (phase == 1) ? SCORE_MAX
                      : $urandom_range(1) ? {$urandom(), 8'($urandom())}
                      : 40'($signed($urandom_range(1 << 26)) - (1 << 25)));
            repeat (60) random_item();
         end
      end
      drain();
      repeat (140) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
